// ===== hdl/tdm_pkg.sv =====
// ============================================================================
// tdm_pkg
// Shared types, constants and table-building functions for the tanh drive
// and dry/wet mix block.
// ============================================================================
package tdm_pkg;

    // Field and register widths.
    localparam int DRIVE_W     = 15;
    localparam int MIX_W       = 16;
    localparam int K_W         = 17;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int TANH_W      = 31;
    localparam int FRAC_F_W    = 16;
    localparam int MIX_SHIFT   = 15;
    localparam int MIX_ROUND   = 16384;

    // Pipeline depth: the lane stages plus the output stage.
    localparam int LANE_STAGES = 7;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    // Register limits and near-zero thresholds.
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 15'd16384;
    localparam logic [DRIVE_W-1:0] DRIVE_EPS = 15'd8;
    localparam logic [MIX_W-1:0]   MIX_ONE   = 16'd32768;
    localparam logic [MIX_W-1:0]   MIX_EPS   = 16'd32;
    localparam logic [K_W-1:0]     K_MAX     = 17'd81920;
    localparam logic [K_W-1:0]     K_EPS     = 17'd40;
    localparam logic [MIX_W-1:0]   MIX_RESET = 16'd16384;

    // Tanh value of 1.0 in Q1.30.
    localparam logic [TANH_W-1:0] TANH_ONE = 31'h4000_0000;

    // Constants used while building the table.
    localparam logic [63:0] ONE62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ONE30 = 64'h0000_0000_4000_0000;
    localparam logic [63:0] HALF32 = 64'h0000_0000_8000_0000;
    localparam int TAYLOR_TERMS = 20;
    localparam int SQUARINGS = 6;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DRIVE_GAIN = 1'b0,
        CFG_WET_MIX    = 1'b1
    } tdm_cfg_index_t;

    // Stage loads and settings that the top level hands to each lane.
    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
        logic [K_W-1:0]         drive_k;
        logic [MIX_W-1:0]       mix;
    } tdm_lane_ctrl_t;

    // Per-transaction flags that travel beside the lanes.
    typedef struct packed {
        logic present;
        logic bypass;
    } tdm_flags_t;

    // Restoring long division, used only while the table is elaborated.
    function automatic logic [63:0] const_udiv(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Truncated product of two Q0.62 values.
    function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Tanh in Q1.30 for an argument arg given as y = arg/32 in Q0.62.
    // exp(-y) comes from a truncated Taylor series, then is squared six times.
    function automatic logic [TANH_W-1:0] tanh_entry(input logic [63:0] y);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e30;
        logic [63:0] den;
        logic [63:0] num;
        term = ONE62;
        sum  = ONE62;
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = const_udiv(mul62(term, y), 64'(n));
            if ((n & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        for (int n = 0; n < SQUARINGS; n++)
        begin
            sum = mul62(sum, sum);
        end
        e30 = (sum + HALF32) >> 32;
        if (e30 > ONE30)
            e30 = ONE30;
        den = ONE30 + e30;
        num = ((ONE30 - e30) << 30) + (den >> 1);
        return TANH_W'(const_udiv(num, den));
    endfunction

endpackage

// ===== hdl/tdm_if.sv =====
// ============================================================================
// tdm_if
// Valid/ready stream interfaces for the stereo input frame and the mixed
// output frame.
// ============================================================================

// Input frame stream.
interface tdm_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic                          is_mono;
    logic                          input_present;

    modport source (
        output valid, sample_left, sample_right, is_mono, input_present,
        input  ready
    );

    modport sink (
        input  valid, sample_left, sample_right, is_mono, input_present,
        output ready
    );
endinterface

// Output frame stream.
interface tdm_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    modport source (
        output valid, out_left, out_right,
        input  ready
    );

    modport sink (
        input  valid, out_left, out_right,
        output ready
    );
endinterface

// ===== hdl/tdm_lane.sv =====
// ============================================================================
// tdm_lane
// One channel of the waveshaper: drive scaling, tanh table lookup with
// linear interpolation, sign restore and dry/wet mix with saturation.
// ============================================================================
module tdm_lane #(
    parameter int SAMPLE_BITS      = 24,
    parameter int TANH_TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  tdm_pkg::tdm_lane_ctrl_t       ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] dry,
    output logic signed [SAMPLE_BITS-1:0] mixed
);
    import tdm_pkg::*;

    localparam int FRAC    = SAMPLE_BITS - 1;
    localparam int ADDR_W  = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int P_W     = K_W + SAMPLE_BITS;
    localparam int S_W     = P_W + ADDR_W;
    localparam int IDX_W   = S_W - FRAC - FRAC_F_W;
    localparam int PROD_W  = TANH_W + FRAC_F_W;
    localparam int WET_W   = SAMPLE_BITS + 1;
    localparam int MP_W    = SAMPLE_BITS + MIX_W + 2;
    localparam int SUM_W   = MP_W + 1;

    localparam logic signed [SUM_W-1:0] MIX_HALF = SUM_W'(MIX_ROUND);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    // Tanh table over arguments 0..8, one more point than intervals.
    typedef logic [TANH_W-1:0] tanh_rom_t [0:TANH_TABLE_DEPTH];

    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t    rom;
        logic [127:0] y;
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++)
        begin
            y      = (128'(i) << 60) / TANH_TABLE_DEPTH;
            rom[i] = tanh_entry(y[63:0]);
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

    // Stage registers.
    logic signed [SAMPLE_BITS-1:0] x_s0_reg, x_s1_reg, x_s2_reg, x_s3_reg;
    logic signed [SAMPLE_BITS-1:0] x_s4_reg, x_s5_reg, x_s6_reg;
    logic [P_W-1:0]                p_s0_reg;
    logic [S_W-1:0]                s_s1_reg;
    logic [TANH_W-1:0]             lo_s2_reg, hi_s2_reg, lo_s3_reg;
    logic [FRAC_F_W-1:0]           frac_s2_reg;
    logic                          sat_s2_reg, sat_s3_reg;
    logic [PROD_W-1:0]             prod_s3_reg;
    logic signed [WET_W-1:0]       wet_s4_reg;
    logic signed [MP_W-1:0]        dry_prod_s5_reg, wet_prod_s5_reg;
    logic signed [SAMPLE_BITS-1:0] mix_s6_reg;

    // Combinational signals between stages.
    logic [SAMPLE_BITS-1:0]        abs_x;
    logic [P_W-1:0]                p_next;
    logic [S_W-1:0]                s_next;
    logic [IDX_W-1:0]              idx;
    logic                          sat_next;
    logic [ADDR_W-1:0]             addr_lo, addr_hi;
    logic [TANH_W-1:0]             diff;
    logic [PROD_W-1:0]             prod_next;
    logic [TANH_W-1:0]             w30;
    logic [SAMPLE_BITS-1:0]        w_round;
    logic signed [WET_W-1:0]       wet_next;
    logic signed [MIX_W:0]         dry_gain, wet_gain;
    logic signed [MP_W-1:0]        dry_prod_next, wet_prod_next;
    logic signed [SUM_W-1:0]       mix_sum, mix_shift;
    logic signed [SAMPLE_BITS-1:0] mix_next;

    // Stage 0: magnitude of the sample times five times the drive.
    always_comb
    begin
        abs_x  = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
        p_next = P_W'(ctrl.drive_k) * P_W'(abs_x);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            x_s0_reg <= sample;
            p_s0_reg <= p_next;
        end
    end

    // Stage 1: scale to table position.
    assign s_next = S_W'(p_s0_reg) * S_W'(TANH_TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            x_s1_reg <= x_s0_reg;
            s_s1_reg <= s_next;
        end
    end

    // Stage 2: split into index and fraction, read both interval ends.
    always_comb
    begin
        idx      = s_s1_reg[S_W-1 -: IDX_W];
        sat_next = (idx >= IDX_W'(TANH_TABLE_DEPTH));
        addr_lo  = sat_next ? '0 : idx[ADDR_W-1:0];
        addr_hi  = addr_lo + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            lo_s2_reg   <= TANH_ROM[addr_lo];
            hi_s2_reg   <= TANH_ROM[addr_hi];
            frac_s2_reg <= s_s1_reg[FRAC +: FRAC_F_W];
            sat_s2_reg  <= sat_next;
            x_s2_reg    <= x_s1_reg;
        end
    end

    // Stage 3: interpolation product over a rising interval.
    always_comb
    begin
        diff      = (hi_s2_reg > lo_s2_reg) ? (hi_s2_reg - lo_s2_reg) : '0;
        prod_next = PROD_W'(diff) * PROD_W'(frac_s2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            lo_s3_reg   <= lo_s2_reg;
            prod_s3_reg <= prod_next;
            sat_s3_reg  <= sat_s2_reg;
            x_s3_reg    <= x_s2_reg;
        end
    end

    // Stage 4: interpolated tanh, rounded to the sample format, signed.
    assign w30 = sat_s3_reg ? TANH_ONE : (lo_s3_reg + TANH_W'(prod_s3_reg >> FRAC_F_W));

    generate
        if (FRAC < 30)
        begin : g_round_down
            localparam int SH = 30 - FRAC;
            localparam logic [TANH_W:0] HALF = {{TANH_W{1'b0}}, 1'b1} << (SH - 1);
            logic [TANH_W:0] w30_rnd;
            assign w30_rnd = {1'b0, w30} + HALF;
            assign w_round = w30_rnd[SH +: SAMPLE_BITS];
        end
        else if (FRAC == 30)
        begin : g_round_same
            assign w_round = w30;
        end
        else
        begin : g_round_up
            assign w_round = {w30, 1'b0};
        end
    endgenerate

    assign wet_next = x_s3_reg[SAMPLE_BITS-1] ? $signed(WET_W'(0) - {1'b0, w_round})
                                              : $signed({1'b0, w_round});

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            wet_s4_reg <= wet_next;
            x_s4_reg   <= x_s3_reg;
        end
    end

    // Stage 5: dry and wet products of the mix.
    always_comb
    begin
        dry_gain      = $signed({1'b0, MIX_ONE - ctrl.mix});
        wet_gain      = $signed({1'b0, ctrl.mix});
        dry_prod_next = MP_W'(dry_gain) * MP_W'(x_s4_reg);
        wet_prod_next = MP_W'(wet_gain) * MP_W'(wet_s4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            dry_prod_s5_reg <= dry_prod_next;
            wet_prod_s5_reg <= wet_prod_next;
            x_s5_reg        <= x_s4_reg;
        end
    end

    // Stage 6: sum, round half up, saturate to the sample range.
    always_comb
    begin
        mix_sum   = SUM_W'(dry_prod_s5_reg) + SUM_W'(wet_prod_s5_reg) + MIX_HALF;
        mix_shift = mix_sum >>> MIX_SHIFT;
        if (mix_shift > SAT_HI)
            mix_next = SAT_HI[SAMPLE_BITS-1:0];
        else if (mix_shift < SAT_LO)
            mix_next = SAT_LO[SAMPLE_BITS-1:0];
        else
            mix_next = mix_shift[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6])
        begin
            mix_s6_reg <= mix_next;
            x_s6_reg   <= x_s5_reg;
        end
    end

    assign dry   = x_s6_reg;
    assign mixed = mix_s6_reg;

endmodule

// ===== hdl/tdm_merge.sv =====
// ============================================================================
// tdm_merge
// Output stage: joins the two lanes into one frame and applies the silence
// and near-zero bypass selections.
// ============================================================================
module tdm_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          load,
    input  tdm_pkg::tdm_flags_t           flags,
    input  logic signed [SAMPLE_BITS-1:0] dry_left,
    input  logic signed [SAMPLE_BITS-1:0] dry_right,
    input  logic signed [SAMPLE_BITS-1:0] mixed_left,
    input  logic signed [SAMPLE_BITS-1:0] mixed_right,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right
);
    import tdm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] out_left_reg, out_left_next;
    logic signed [SAMPLE_BITS-1:0] out_right_reg, out_right_next;

    // Silence wins, then the dry bypass, else the processed frame.
    always_comb
    begin
        if (!flags.present)
        begin
            out_left_next  = '0;
            out_right_next = '0;
        end
        else if (flags.bypass)
        begin
            out_left_next  = dry_left;
            out_right_next = dry_right;
        end
        else
        begin
            out_left_next  = mixed_left;
            out_right_next = mixed_right;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_left_reg  <= out_left_next;
            out_right_reg <= out_right_next;
        end
    end

    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

endmodule

// ===== hdl/tanh_drive_dry_wet_mix.sv =====
// ============================================================================
// tanh_drive_dry_wet_mix
// Stereo tanh soft-clip drive with dry/wet mix: two channel lanes, a merge
// stage, the valid/ready pipeline control and the configuration registers.
// ============================================================================
// Pipeline: a frame's result passes through 7 lane stages and the output
//   register after its transaction is accepted.
// Throughput: one frame per cycle while the output is ready; each lane reads
//   both ends of its tanh interval from a two-port table; stalls fill bubbles.
// Reset: clears the pipeline valids, drive to 0 and mix to 16384; the tanh
//   table is constant, so no clearing pass is needed.
module tanh_drive_dry_wet_mix #(
    parameter int SAMPLE_BITS      = 24,
    parameter int TANH_TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tdm_in_if.sink                             dry,
    tdm_out_if.source                          mixed,
    input  logic                               cfg_wr_en,
    input  logic [tdm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tdm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tdm_pkg::*;

    // Configuration registers, held clamped and pre-scaled.
    logic [K_W-1:0]     drive_k_reg, drive_k_next;
    logic               drive_small_reg, drive_small_next;
    logic [MIX_W-1:0]   mix_reg, mix_next;
    logic [DRIVE_W-1:0] drive_clamp;
    logic [MIX_W-1:0]   mix_clamp;

    // Pipeline control.
    logic [PIPE_STAGES-1:0] valid_reg, valid_next;
    logic [PIPE_STAGES-1:0] free;
    logic [PIPE_STAGES-1:0] load;
    tdm_flags_t             flags_reg [LANE_STAGES];
    tdm_flags_t             flags_in;

    // Lane connections.
    tdm_lane_ctrl_t                lane_ctrl;
    logic signed [SAMPLE_BITS-1:0] right_sel;
    logic signed [SAMPLE_BITS-1:0] dry_left, dry_right, lane_left, lane_right;
    logic signed [SAMPLE_BITS-1:0] merged_left, merged_right;

    // Configuration write decode with range clamping.
    always_comb
    begin
        drive_k_next     = drive_k_reg;
        drive_small_next = drive_small_reg;
        mix_next         = mix_reg;
        drive_clamp      = (cfg_wdata[DRIVE_W-1:0] > DRIVE_MAX) ? DRIVE_MAX
                                                                 : cfg_wdata[DRIVE_W-1:0];
        mix_clamp        = (cfg_wdata > MIX_ONE) ? MIX_ONE : cfg_wdata;
        if (cfg_wr_en)
        begin
            unique case (tdm_cfg_index_t'(cfg_index))
                CFG_DRIVE_GAIN:
                begin
                    drive_k_next     = (K_W'(drive_clamp) << 2) + K_W'(drive_clamp);
                    drive_small_next = (drive_clamp <= DRIVE_EPS);
                end
                CFG_WET_MIX:
                begin
                    mix_next = mix_clamp;
                end
                default:
                begin
                    mix_next = mix_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_k_reg     <= '0;
            drive_small_reg <= 1'b1;
            mix_reg         <= MIX_RESET;
        end
        else
        begin
            drive_k_reg     <= drive_k_next;
            drive_small_reg <= drive_small_next;
            mix_reg         <= mix_next;
        end
    end

    // A stage is free when empty or when the stage after it moves on.
    always_comb
    begin
        free[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || mixed.ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            free[i] = !valid_reg[i] || free[i+1];
        end
        load[0]       = dry.valid && free[0];
        valid_next[0] = free[0] ? dry.valid : valid_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            load[i]       = valid_reg[i-1] && free[i];
            valid_next[i] = free[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Per-transaction flags follow the lane stages.
    assign flags_in.present = dry.input_present;
    assign flags_in.bypass  = drive_small_reg && (mix_reg <= MIX_EPS);

    always_ff @(posedge clk)
    begin
        if (load[0])
            flags_reg[0] <= flags_in;
        for (int i = 1; i < LANE_STAGES; i++)
        begin
            if (load[i])
                flags_reg[i] <= flags_reg[i-1];
        end
    end

    // Lanes: mono input feeds the left sample to both channels.
    assign right_sel      = dry.is_mono ? dry.sample_left : dry.sample_right;
    assign lane_ctrl.load    = load[LANE_STAGES-1:0];
    assign lane_ctrl.drive_k = drive_k_reg;
    assign lane_ctrl.mix     = mix_reg;

    tdm_lane #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_lane_left (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .sample (dry.sample_left),
        .dry    (dry_left),
        .mixed  (lane_left)
    );

    tdm_lane #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_lane_right (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .sample (right_sel),
        .dry    (dry_right),
        .mixed  (lane_right)
    );

    // Output stage.
    tdm_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk         (clk),
        .load        (load[PIPE_STAGES-1]),
        .flags       (flags_reg[LANE_STAGES-1]),
        .dry_left    (dry_left),
        .dry_right   (dry_right),
        .mixed_left  (lane_left),
        .mixed_right (lane_right),
        .out_left    (merged_left),
        .out_right   (merged_right)
    );

    assign dry.ready       = free[0];
    assign mixed.valid     = valid_reg[PIPE_STAGES-1];
    assign mixed.out_left  = merged_left;
    assign mixed.out_right = merged_right;

    // Input back-pressure only when every stage holds a transaction.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !dry.ready |-> (&valid_reg))
        else $error("input stalled while the pipeline has a free stage");

    // Stored settings stay inside their clamped ranges.
    a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_k_reg <= K_MAX) && (mix_reg <= MIX_ONE))
        else $error("configuration register out of range");

    // The near-zero drive flag agrees with the scaled drive.
    a_drive_small: assert property (@(posedge clk) disable iff (!rst_n)
        drive_small_reg == (drive_k_reg <= K_EPS))
        else $error("drive bypass flag disagrees with drive setting");

    // A result appears only when the last lane stage held one.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mixed.valid) |-> $past(valid_reg[PIPE_STAGES-2]))
        else $error("output valid rose without a transaction behind it");

endmodule
